[rtl/srsd_pkg.sv]
// Shared types and constants for the serial receive status deframer.
package srsd_pkg;

  // Character flag codes carried with each result.
  typedef enum logic [2:0] {
    FLAG_STATUS  = 3'd0,
    FLAG_NORMAL  = 3'd1,
    FLAG_BREAK   = 3'd2,
    FLAG_PARITY  = 3'd3,
    FLAG_FRAMING = 3'd4,
    FLAG_OVERRUN = 3'd5
  } flag_t;

  // Status event codes shown on a status record.
  typedef enum logic [1:0] {
    EVENT_NONE  = 2'd0,
    EVENT_MODEM = 2'd1,
    EVENT_BREAK = 2'd2
  } event_t;

  // Header bytes.
  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] KIND_LINE  = 8'h00;
  localparam logic [7:0] KIND_MODEM = 8'h01;

  // Byte positions within a packet.
  localparam logic [2:0] POS_STATUS = 3'd3;
  localparam logic [2:0] POS_BODY   = 3'd4;

  // Event counter slots.
  localparam int unsigned NUM_CNT = 8;
  localparam logic [2:0] CNT_BREAK   = 3'd0;
  localparam logic [2:0] CNT_PARITY  = 3'd1;
  localparam logic [2:0] CNT_FRAMING = 3'd2;
  localparam logic [2:0] CNT_OVERRUN = 3'd3;
  localparam logic [2:0] CNT_CTS     = 3'd4;
  localparam logic [2:0] CNT_DSR     = 3'd5;
  localparam logic [2:0] CNT_DCD     = 3'd6;
  localparam logic [2:0] CNT_RING    = 3'd7;

  // Width of the counter values shown on the result ports.
  localparam int unsigned SHOW_BITS = 16;

endpackage

[rtl/serial_rx_status_deframer_core.sv]
// Top level of the serial receive status deframer: header detection, counters and result queue.
//
// Packet bytes are accepted one per cycle unless in_stall is raised. Each byte is decoded in the
// cycle it is accepted and its results (none to four) are loaded into a result group register,
// which hands them out one per cycle while the receiver does not stall. A byte that yields a
// single result or none therefore sustains one transaction per cycle when the receiver does not
// stall; a byte that yields several results stalls the input while the group register drains
// and while the receiver stalls. The first three bytes of a packet are held back until the
// header can be judged, so a short packet or a packet without a header releases them
// together.
// The eight event counters are COUNT_BITS wide and wrap; their low 16 bits are
// shown with every result and reflect the updates made by the byte that caused it.
module serial_rx_status_deframer_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_packet_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_byte,
  output logic [2:0]  out_char_flag,
  output logic        out_last_of_run,
  output logic [1:0]  out_status_event,
  output logic [15:0] out_break_count,
  output logic [15:0] out_parity_count,
  output logic [15:0] out_framing_count,
  output logic [15:0] out_overrun_count,
  output logic [15:0] out_cts_change_count,
  output logic [15:0] out_dsr_change_count,
  output logic [15:0] out_dcd_change_count,
  output logic [15:0] out_ring_change_count
);

  // Packet state.
  logic [2:0]           pos_r, pos_nxt;
  logic [7:0]           held_r [3];
  srsd_pkg::flag_t      pflag_r, pflag_nxt;
  logic [COUNT_BITS-1:0] cnt_r [srsd_pkg::NUM_CNT];

  // Result group.
  logic [2:0]           grp_cnt_r;
  logic [1:0]           grp_idx_r;
  logic [7:0]           grp_char_r [4];
  srsd_pkg::flag_t      grp_flag_r [4];
  srsd_pkg::event_t     grp_ev_r;

  // Decode of the byte on the input.
  logic [2:0]           res_n;
  logic [7:0]           res_char [4];
  srsd_pkg::flag_t      res_flag [4];
  srsd_pkg::event_t     res_ev;
  logic [srsd_pkg::NUM_CNT-1:0] bump;
  logic                 hdr;

  logic accept, pop, last;

  assign out_valid = (grp_cnt_r != 3'd0);
  assign last      = (({1'b0, grp_idx_r} + 3'd1) == grp_cnt_r);
  assign pop       = out_valid && !out_stall;
  // The group register is free once its final result leaves in this cycle.
  assign in_stall  = out_valid && !(pop && last);
  assign accept    = in_valid && !in_stall;

  assign hdr = (held_r[0] == srsd_pkg::ESC_BYTE) && (held_r[1] == srsd_pkg::ESC_BYTE) &&
               ((held_r[2] == srsd_pkg::KIND_LINE) || (held_r[2] == srsd_pkg::KIND_MODEM));

  always_comb begin
    res_n     = 3'd0;
    res_ev    = srsd_pkg::EVENT_NONE;
    bump      = '0;
    pos_nxt   = pos_r;
    pflag_nxt = pflag_r;
    for (int i = 0; i < 4; i++) begin
      res_char[i] = in_rx_byte;
      res_flag[i] = srsd_pkg::FLAG_NORMAL;
    end

    if (pos_r < srsd_pkg::POS_STATUS) begin
      // Header bytes are held; on an early packet end they all go out as data.
      for (int i = 0; i < 3; i++) begin
        res_char[i] = (pos_r[1:0] == 2'(i)) ? in_rx_byte : held_r[i];
      end
      if (in_packet_end) begin
        res_n = pos_r + 3'd1;
      end
      pos_nxt = pos_r + 3'd1;
    end else if (pos_r == srsd_pkg::POS_STATUS) begin
      pos_nxt = srsd_pkg::POS_BODY;
      if (!hdr) begin
        res_n = 3'd4;
        for (int i = 0; i < 3; i++) begin
          res_char[i] = held_r[i];
        end
      end else if (held_r[2] == srsd_pkg::KIND_LINE) begin
        res_flag[0] = srsd_pkg::FLAG_STATUS;
        bump[srsd_pkg::CNT_BREAK]   = in_rx_byte[4];
        bump[srsd_pkg::CNT_PARITY]  = in_rx_byte[2];
        bump[srsd_pkg::CNT_FRAMING] = in_rx_byte[3];
        bump[srsd_pkg::CNT_OVERRUN] = in_rx_byte[1];
        if (in_rx_byte[4]) begin
          pflag_nxt = srsd_pkg::FLAG_BREAK;
          res_ev    = srsd_pkg::EVENT_BREAK;
        end else if (in_rx_byte[2]) begin
          pflag_nxt = srsd_pkg::FLAG_PARITY;
        end else if (in_rx_byte[3]) begin
          pflag_nxt = srsd_pkg::FLAG_FRAMING;
        end else begin
          pflag_nxt = srsd_pkg::FLAG_NORMAL;
        end
        // An overrun inserts a zero character after the status record.
        res_char[1] = 8'h00;
        res_flag[1] = srsd_pkg::FLAG_OVERRUN;
        res_n       = in_rx_byte[1] ? 3'd2 : 3'd1;
      end else begin
        res_flag[0] = srsd_pkg::FLAG_STATUS;
        res_n       = 3'd1;
        bump[srsd_pkg::CNT_CTS]  = in_rx_byte[0];
        bump[srsd_pkg::CNT_DSR]  = in_rx_byte[1];
        bump[srsd_pkg::CNT_RING] = in_rx_byte[2];
        bump[srsd_pkg::CNT_DCD]  = in_rx_byte[3];
        if (in_rx_byte[3:0] != 4'd0) begin
          res_ev = srsd_pkg::EVENT_MODEM;
        end
      end
    end else begin
      res_n       = 3'd1;
      res_flag[0] = pflag_r;
    end

    if (in_packet_end) begin
      pos_nxt   = 3'd0;
      pflag_nxt = srsd_pkg::FLAG_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 3'd0;
      pflag_r   <= srsd_pkg::FLAG_NORMAL;
      grp_cnt_r <= 3'd0;
      grp_idx_r <= 2'd0;
      for (int k = 0; k < srsd_pkg::NUM_CNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      // A new group can only load when the group register is empty or its final
      // result leaves in this cycle, so loading takes precedence over popping.
      if (accept && (res_n != 3'd0)) begin
        grp_cnt_r <= res_n;
        grp_idx_r <= 2'd0;
      end else if (pop) begin
        if (last) begin
          grp_cnt_r <= 3'd0;
        end else begin
          grp_idx_r <= grp_idx_r + 2'd1;
        end
      end
      if (accept) begin
        pos_r   <= pos_nxt;
        pflag_r <= pflag_nxt;
        for (int k = 0; k < srsd_pkg::NUM_CNT; k++) begin
          if (bump[k]) begin
            cnt_r[k] <= cnt_r[k] + COUNT_BITS'(1);
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos_r < srsd_pkg::POS_STATUS) begin
        held_r[pos_r[1:0]] <= in_rx_byte;
      end
      if (res_n != 3'd0) begin
        grp_ev_r <= res_ev;
        for (int i = 0; i < 4; i++) begin
          grp_char_r[i] <= res_char[i];
          grp_flag_r[i] <= res_flag[i];
        end
      end
    end
  end

  // The status event rides only on the first result of a transaction group.
  assign out_char_byte    = grp_char_r[grp_idx_r];
  assign out_char_flag    = grp_flag_r[grp_idx_r];
  assign out_last_of_run  = last;
  assign out_status_event = (grp_idx_r == 2'd0) ? grp_ev_r : srsd_pkg::EVENT_NONE;

  // Counters only move when a status byte is taken, and that byte always loads a new group.
  assign out_break_count       = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_BREAK]);
  assign out_parity_count      = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_PARITY]);
  assign out_framing_count     = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_FRAMING]);
  assign out_overrun_count     = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_OVERRUN]);
  assign out_cts_change_count  = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_CTS]);
  assign out_dsr_change_count  = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_DSR]);
  assign out_dcd_change_count  = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_DCD]);
  assign out_ring_change_count = srsd_pkg::SHOW_BITS'(cnt_r[srsd_pkg::CNT_RING]);

endmodule
